[sv/anemometer_speed_meter_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the anemometer speed meter
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef ANEMOMETER_SPEED_METER_CORE_MACROS_SVH
`define ANEMOMETER_SPEED_METER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define ANEM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication in the next cycle, outside reset
`define ANEM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

[sv/anem_pkg.sv]
// ---------------------------------------------------------------------------
// Anemometer speed meter package
// Types, codes and constants shared by the controller, datapath and top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package anem_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned TALLY_W = 16;
  localparam int unsigned CSPD_W  = 32;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned STEP_W  = 5;

  // Item codes
  localparam logic ACT_PULSE = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_PERIOD_GAIN = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_COUNT_GAIN  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_STALE_LIMIT = 2'd2;

  // Configuration reset values
  localparam logic [23:0] PERIOD_GAIN_RST = 24'd926982;
  localparam logic [15:0] COUNT_GAIN_RST  = 16'd927;
  localparam logic [7:0]  STALE_LIMIT_RST = 8'd4;

  // Divider runs one quotient bit per step
  localparam logic [STEP_W-1:0] DIV_LAST_STEP = 5'(SPEED_W - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } anem_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic div_step;    // advance the divider one bit
    logic div_finish;  // last divider step, write the speed
  } anem_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;    // offered beat is a pulse after an earlier pulse, with a non-zero gap
    logic div_last;    // divider is on its final bit
  } anem_status_t;

endpackage

[sv/anem_if.sv]
// ---------------------------------------------------------------------------
// Anemometer channel interfaces
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface anem_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] time_ms;

  modport source (output valid, output action, output time_ms, input ready);
  modport sink   (input valid, input action, input time_ms, output ready);
endinterface

interface anem_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] period_speed;
  logic [31:0] count_speed;
  logic        stale_zeroed;

  modport source (output valid, output period_speed, output count_speed,
                  output stale_zeroed, input ready);
  modport sink   (input valid, input period_speed, input count_speed,
                  input stale_zeroed, output ready);
endinterface

[sv/anem_ctrl.sv]
// ---------------------------------------------------------------------------
// Anemometer speed meter controller
// Sequences input beats, the serial divider and the result handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anemometer_speed_meter_core_macros.svh"

module anem_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  anem_pkg::anem_status_t status,
  output anem_pkg::anem_cmd_t   cmd
);

  anem_pkg::anem_state_t state;
  anem_pkg::anem_state_t state_next;
  logic                  out_valid_next;

  // Advance state
  always_comb begin
    state_next = state;
    unique case (state)
      anem_pkg::ST_IDLE: begin
        if (cmd.accept && status.need_div) state_next = anem_pkg::ST_DIVIDE;
      end
      anem_pkg::ST_DIVIDE: begin
        if (status.div_last) state_next = anem_pkg::ST_IDLE;
      end
      default: state_next = anem_pkg::ST_IDLE;
    endcase
  end

  // Drive commands and the result valid
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      anem_pkg::ST_IDLE: begin
        in_ready   = !out_valid || out_ready;
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && !status.need_div) out_valid_next = 1'b1;
      end
      anem_pkg::ST_DIVIDE: begin
        cmd.div_step   = 1'b1;
        cmd.div_finish = status.div_last;
        if (status.div_last) out_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= anem_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ANEM_ASSERT(a_no_result_while_dividing, !(state == anem_pkg::ST_DIVIDE && out_valid), "result shown during divide")
  `ANEM_ASSERT_NEXT(a_quick_item_gives_result, cmd.accept && !status.need_div, out_valid, "result missing after item")
  `ANEM_ASSERT_NEXT(a_finish_gives_result, cmd.div_finish, out_valid && state == anem_pkg::ST_IDLE, "divide did not end in result")

endmodule

[sv/anem_dp.sv]
// ---------------------------------------------------------------------------
// Anemometer speed meter datapath
// Configuration, meter state, serial restoring divider and count multiply.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "anemometer_speed_meter_core_macros.svh"

module anem_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [anem_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [anem_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               action,
  input  logic [anem_pkg::TIME_W-1:0]        time_ms,
  input  anem_pkg::anem_cmd_t                cmd,
  output anem_pkg::anem_status_t             status,
  output logic [anem_pkg::SPEED_W-1:0]       period_speed,
  output logic [anem_pkg::CSPD_W-1:0]        count_speed,
  output logic                               stale_zeroed
);

  // Configuration
  logic [23:0] period_gain;
  logic [15:0] count_gain;
  logic [7:0]  stale_limit;

  // Meter state
  logic [anem_pkg::TIME_W-1:0]  prev_pulse_time;
  logic                         have_prev_pulse;
  logic [anem_pkg::SPEED_W-1:0] speed_now;
  logic [anem_pkg::SPEED_W-1:0] speed_at_last_check;
  logic [anem_pkg::RUN_W-1:0]   unchanged_run;
  logic [anem_pkg::TALLY_W-1:0] pulse_tally;
  logic [anem_pkg::CSPD_W-1:0]  tally_speed;
  logic                         zeroed;

  // Divider
  logic [anem_pkg::TIME_W-1:0]  div_rem;
  logic [anem_pkg::TIME_W-1:0]  div_den;
  logic [anem_pkg::SPEED_W-1:0] div_quo;
  logic [anem_pkg::STEP_W-1:0]  div_count;

  logic [anem_pkg::TIME_W-1:0]  gap;
  logic [anem_pkg::TIME_W:0]    trial;
  logic [anem_pkg::TIME_W-1:0]  rem_next;
  logic [anem_pkg::SPEED_W-1:0] quo_next;
  logic [anem_pkg::RUN_W-1:0]   run_next;
  logic                         stale_hit;
  logic [anem_pkg::TALLY_W-1:0] tally_inc;

  // Gap to previous pulse, wrapping
  assign gap = time_ms - prev_pulse_time;

  assign status.need_div = (action == anem_pkg::ACT_PULSE) && have_prev_pulse && (gap != '0);
  assign status.div_last = (div_count == anem_pkg::DIV_LAST_STEP);

  // One restoring divide step
  always_comb begin
    trial = {div_rem, div_quo[anem_pkg::SPEED_W-1]} - {1'b0, div_den};
    if (!trial[anem_pkg::TIME_W]) begin
      rem_next = trial[anem_pkg::TIME_W-1:0];
      quo_next = {div_quo[anem_pkg::SPEED_W-2:0], 1'b1};
    end else begin
      rem_next = {div_rem[anem_pkg::TIME_W-2:0], div_quo[anem_pkg::SPEED_W-1]};
      quo_next = {div_quo[anem_pkg::SPEED_W-2:0], 1'b0};
    end
  end

  // Check-tick run bookkeeping
  always_comb begin
    if (speed_now == speed_at_last_check) begin
      run_next = (unchanged_run != '1) ? unchanged_run + 1'b1 : unchanged_run;
    end else begin
      run_next = '0;
    end
    stale_hit = (run_next >= stale_limit);
  end

  assign tally_inc = (pulse_tally != '1) ? pulse_tally + 1'b1 : pulse_tally;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      period_gain <= anem_pkg::PERIOD_GAIN_RST;
      count_gain  <= anem_pkg::COUNT_GAIN_RST;
      stale_limit <= anem_pkg::STALE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        anem_pkg::CFG_PERIOD_GAIN: period_gain <= cfg_data;
        anem_pkg::CFG_COUNT_GAIN:  count_gain  <= cfg_data[15:0];
        anem_pkg::CFG_STALE_LIMIT: stale_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Update meter state on each beat and at the end of a divide
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pulse_time     <= '0;
      have_prev_pulse     <= 1'b0;
      speed_now           <= '0;
      speed_at_last_check <= '0;
      unchanged_run       <= '0;
      pulse_tally         <= '0;
      tally_speed         <= '0;
      zeroed              <= 1'b0;
    end else if (cmd.accept) begin
      if (action == anem_pkg::ACT_PULSE) begin
        pulse_tally     <= tally_inc;
        prev_pulse_time <= time_ms;
        have_prev_pulse <= 1'b1;
        zeroed          <= 1'b0;
        if (have_prev_pulse && gap == '0) speed_now <= '1;
      end else begin
        zeroed      <= stale_hit;
        tally_speed <= {16'd0, pulse_tally} * {16'd0, count_gain};
        pulse_tally <= '0;
        if (stale_hit) begin
          speed_now           <= '0;
          unchanged_run       <= '0;
          speed_at_last_check <= '0;
        end else begin
          unchanged_run       <= run_next;
          speed_at_last_check <= speed_now;
        end
      end
    end else if (cmd.div_finish) begin
      speed_now <= quo_next;
    end
  end

  // Load and run the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_count <= '0;
    end else if (cmd.accept) begin
      div_count <= '0;
    end else if (cmd.div_step) begin
      div_count <= div_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      div_rem <= '0;
      div_den <= gap;
      div_quo <= period_gain;
    end else if (cmd.div_step) begin
      div_rem <= rem_next;
      div_quo <= quo_next;
    end
  end

  assign period_speed = speed_now;
  assign count_speed  = tally_speed;
  assign stale_zeroed = zeroed;

  `ANEM_ASSERT(a_zeroed_means_zero_speed, !zeroed || speed_now == '0, "stale flag with non-zero speed")
  `ANEM_ASSERT_NEXT(a_pulse_counted, cmd.accept && action == anem_pkg::ACT_PULSE, pulse_tally != '0 && have_prev_pulse, "pulse not recorded")
  `ANEM_ASSERT_NEXT(a_check_clears_tally, cmd.accept && action == anem_pkg::ACT_CHECK, pulse_tally == '0, "tally not cleared by check")

endmodule

[sv/anemometer_speed_meter_core.sv]
// Results: a check tick, a first pulse or a zero-gap pulse gives its result in the cycle after accept;
// a pulse with a non-zero gap gives it once the divider has run its 24 steps.
// Throughput: one item per cycle without a divide, while results are taken; none is taken while
// the one-bit-per-cycle restoring divider runs. A new item is taken once the last result is taken.
// Reset (rst, synchronous): gains 926982 / 927, stale limit 4, all meter state cleared.
// ---------------------------------------------------------------------------
// Anemometer speed meter core
// Pulse-period and pulse-count wind speed in km/h with 8 fraction bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module anemometer_speed_meter_core (
  input  logic                         clk,
  input  logic                         rst,
  anem_in_if.sink                      sample,
  anem_out_if.source                   result,
  input  logic                         cfg_we,
  input  logic [anem_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [anem_pkg::CFG_W-1:0]   cfg_data
);

  anem_pkg::anem_cmd_t    cmd;
  anem_pkg::anem_status_t status;

  // Sequence beats and the divider
  anem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold configuration and meter state
  anem_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (sample.action),
    .time_ms      (sample.time_ms),
    .cmd          (cmd),
    .status       (status),
    .period_speed (result.period_speed),
    .count_speed  (result.count_speed),
    .stale_zeroed (result.stale_zeroed)
  );

endmodule
